// ----- rtl/rta_pkg.sv -----
// ----------------------------------------------------------------------------
// Route table package
// Shared types, sizes and codes for the route table with aging.
// ----------------------------------------------------------------------------
package rta_pkg;

  // Table geometry.
  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  // Fixed field widths of the request and response.
  localparam int unsigned AddrW   = 16;
  localparam int unsigned LifeW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned UsedW   = 6;

  // Configuration port.
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam int unsigned RegSel = 2;  // paddr bit that selects the register

  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [LifeW-1:0]   life_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [SlotW-1:0]   slot_t;
  typedef logic [UsedW-1:0]   used_t;

  localparam cnt_t FullCount = cnt_t'(TableDepth);

  // Register indexes.
  localparam logic REG_OWN_NODE_ID = 1'b0;
  localparam logic REG_LIFE_RELOAD = 1'b1;

  localparam addr_t OwnNodeIdReset  = '0;
  localparam life_t LifeReloadReset = life_t'(3);

  // Request commands.
  localparam logic CMD_RESPONSE = 1'b0;
  localparam logic CMD_AGE      = 1'b1;

  // Response status codes.
  localparam status_t STATUS_UPDATED        = status_t'(0);
  localparam status_t STATUS_INSERTED       = status_t'(1);
  localparam status_t STATUS_NOT_ADDRESSED  = status_t'(2);
  localparam status_t STATUS_FULL_COMPACTED = status_t'(3);
  localparam status_t STATUS_AGED           = status_t'(4);

  typedef struct packed {
    logic  cmd;
    addr_t resp_target;
    addr_t route_dest;
    addr_t hop_addr;
  } in_req_t;

  typedef struct packed {
    status_t status;
    slot_t   slot;
    used_t   used_count;
  } out_rsp_t;

  typedef struct packed {
    addr_t own_node_id;
    life_t life_reload;
  } cfg_t;

  typedef struct packed {
    addr_t dest;
    addr_t hop;
    life_t life;
  } entry_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } mem_rd_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } mem_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MODE_AGE,
    MODE_NOADDR,
    MODE_SEARCH,
    MODE_COMPACT
  } mode_e;

endpackage

// ----- rtl/rta_table_mem.sv -----
// ----------------------------------------------------------------------------
// Route table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rta_table_mem (
  input  logic             clk_i,
  input  rta_pkg::mem_rd_t rd_i,
  input  rta_pkg::mem_wr_t wr_i,
  output rta_pkg::entry_t  rdata_o
);

  rta_pkg::entry_t mem [rta_pkg::TableDepth];
  rta_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rta_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Route table configuration registers
// APB-style register file for the node id and the life reload value.
// ----------------------------------------------------------------------------
module rta_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rta_pkg::PaddrW-1:0]  paddr,
  input  logic [rta_pkg::PdataW-1:0]  pwdata,
  output logic [rta_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  output rta_pkg::cfg_t               cfg_o
);

  rta_pkg::cfg_t cfg_q, cfg_d;
  logic          reg_idx;

  assign reg_idx = paddr[rta_pkg::RegSel];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        rta_pkg::REG_OWN_NODE_ID: cfg_d.own_node_id = pwdata[rta_pkg::AddrW-1:0];
        rta_pkg::REG_LIFE_RELOAD: cfg_d.life_reload = pwdata[rta_pkg::LifeW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rta_pkg::REG_OWN_NODE_ID: prdata = rta_pkg::PdataW'(cfg_q.own_node_id);
      rta_pkg::REG_LIFE_RELOAD: prdata = rta_pkg::PdataW'(cfg_q.life_reload);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_node_id <= rta_pkg::OwnNodeIdReset;
      cfg_q.life_reload <= rta_pkg::LifeReloadReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/rta_ctrl.sv -----
// ----------------------------------------------------------------------------
// Route table controller
// Walks the table memory for search, aging and compaction and holds the
// response register.
// ----------------------------------------------------------------------------
module rta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rta_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rta_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rta_pkg::out_rsp_t out_rsp_o,
  output rta_pkg::mem_rd_t  rd_o,
  output rta_pkg::mem_wr_t  wr_o,
  input  rta_pkg::entry_t   rdata_i
);

  rta_pkg::ctrl_state_e state_q, state_d;
  rta_pkg::mode_e       mode_q, mode_d;
  rta_pkg::in_req_t     req_q, req_d;
  rta_pkg::cnt_t        idx_q, idx_d;
  rta_pkg::cnt_t        kept_q, kept_d;
  rta_pkg::cnt_t        fill_q, fill_d;
  rta_pkg::cnt_t        fill_inc;
  rta_pkg::idx_t        didx_q;
  logic                 dv_q;
  rta_pkg::out_rsp_t    res_q, res_d;
  rta_pkg::out_rsp_t    out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 walk_done;
  logic                 accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == rta_pkg::ST_IDLE);
  assign fill_inc   = fill_q + rta_pkg::cnt_t'(1);

  // Every entry has been issued and the last read data has been consumed.
  assign walk_done = !dv_q && (idx_q == fill_q);

  always_comb begin
    rd_o.en   = (state_q == rta_pkg::ST_SCAN) && (mode_q != rta_pkg::MODE_NOADDR) &&
                (idx_q < fill_q);
    rd_o.addr = idx_q[rta_pkg::IdxW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    req_d       = req_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    fill_d      = fill_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_o.en     = 1'b0;
    wr_o.addr   = didx_q;
    wr_o.data   = rdata_i;

    if (rd_o.en) begin
      idx_d = idx_q + rta_pkg::cnt_t'(1);
    end

    case (state_q)
      rta_pkg::ST_IDLE: begin
        if (accept) begin
          req_d  = in_req_i;
          idx_d  = '0;
          kept_d = '0;
          if (in_req_i.cmd == rta_pkg::CMD_AGE) begin
            mode_d = rta_pkg::MODE_AGE;
          end else if (in_req_i.resp_target != cfg_i.own_node_id) begin
            mode_d = rta_pkg::MODE_NOADDR;
          end else if (fill_q < rta_pkg::FullCount) begin
            mode_d = rta_pkg::MODE_SEARCH;
          end else begin
            mode_d = rta_pkg::MODE_COMPACT;
          end
          state_d = rta_pkg::ST_SCAN;
        end
      end

      rta_pkg::ST_SCAN: begin
        case (mode_q)
          rta_pkg::MODE_NOADDR: begin
            res_d.status     = rta_pkg::STATUS_NOT_ADDRESSED;
            res_d.slot       = '0;
            res_d.used_count = rta_pkg::used_t'(fill_q);
            state_d          = rta_pkg::ST_DONE;
          end
          rta_pkg::MODE_SEARCH: begin
            if (dv_q && (rdata_i.dest == req_q.route_dest)) begin
              wr_o.en          = 1'b1;
              wr_o.addr        = didx_q;
              wr_o.data.dest   = req_q.route_dest;
              wr_o.data.hop    = req_q.hop_addr;
              wr_o.data.life   = cfg_i.life_reload;
              res_d.status     = rta_pkg::STATUS_UPDATED;
              res_d.slot       = rta_pkg::slot_t'(didx_q);
              res_d.used_count = rta_pkg::used_t'(fill_q);
              state_d          = rta_pkg::ST_DONE;
            end else if (walk_done) begin
              wr_o.en          = 1'b1;
              wr_o.addr        = fill_q[rta_pkg::IdxW-1:0];
              wr_o.data.dest   = req_q.route_dest;
              wr_o.data.hop    = req_q.hop_addr;
              wr_o.data.life   = cfg_i.life_reload;
              fill_d           = fill_inc;
              res_d.status     = rta_pkg::STATUS_INSERTED;
              res_d.slot       = rta_pkg::slot_t'(fill_q);
              res_d.used_count = rta_pkg::used_t'(fill_inc);
              state_d          = rta_pkg::ST_DONE;
            end
          end
          rta_pkg::MODE_AGE: begin
            if (dv_q && (rdata_i.life != '0)) begin
              wr_o.en        = 1'b1;
              wr_o.addr      = didx_q;
              wr_o.data.life = rdata_i.life - rta_pkg::life_t'(1);
            end
            if (walk_done) begin
              res_d.status     = rta_pkg::STATUS_AGED;
              res_d.slot       = '0;
              res_d.used_count = rta_pkg::used_t'(fill_q);
              state_d          = rta_pkg::ST_DONE;
            end
          end
          rta_pkg::MODE_COMPACT: begin
            // Live entries slide down to the kept position; the read pointer
            // always runs ahead of the write pointer.
            if (dv_q && (rdata_i.life != '0)) begin
              wr_o.en   = 1'b1;
              wr_o.addr = kept_q[rta_pkg::IdxW-1:0];
              kept_d    = kept_q + rta_pkg::cnt_t'(1);
            end
            if (walk_done) begin
              fill_d           = kept_q;
              res_d.status     = rta_pkg::STATUS_FULL_COMPACTED;
              res_d.slot       = '0;
              res_d.used_count = rta_pkg::used_t'(kept_q);
              state_d          = rta_pkg::ST_DONE;
            end
          end
          default: state_d = rta_pkg::ST_DONE;
        endcase
      end

      rta_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = rta_pkg::ST_IDLE;
        end
      end

      default: state_d = rta_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rta_pkg::ST_IDLE;
      mode_q      <= rta_pkg::MODE_AGE;
      idx_q       <= '0;
      kept_q      <= '0;
      fill_q      <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      fill_q      <= fill_d;
      dv_q        <= rd_o.en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    didx_q <= rd_o.addr;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The table never holds more entries than it has rows.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= rta_pkg::FullCount)
    else $error("fill level beyond table depth");

  // Reads and writes never touch the same row in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.en && rd_o.en) |-> (wr_o.addr != rd_o.addr))
    else $error("read and write to the same row");

  // Compaction never writes ahead of the entry being examined.
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rta_pkg::ST_SCAN && mode_q == rta_pkg::MODE_COMPACT && dv_q) |->
    (kept_q <= rta_pkg::cnt_t'(didx_q)))
    else $error("compaction write pointer passed read pointer");

  // A finished result is moved into a free response register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rta_pkg::ST_DONE && (!out_valid_q || out_ready_i)) |=>
    (out_valid_q && state_q == rta_pkg::ST_IDLE))
    else $error("result not loaded into response register");

  // The table is only written while a request is being worked on.
  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (state_q == rta_pkg::ST_SCAN))
    else $error("table write outside of a scan");

endmodule

// ----- rtl/route_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// Route table with aging
// Keeps up to TableDepth routes (destination, next hop, life) in one table
// memory and updates, inserts, ages or compacts them one request at a time.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                   Direction
//   -------   ---------------------------------------   ---------
//   in        in_valid_i / in_ready_o / in_req_i         request in
//   out       out_valid_o / out_ready_i / out_rsp_o      response out
//   cfg       psel penable pwrite paddr pwdata prdata    register port
//
// The controller accepts a request, then issues one table read per cycle
// through the single read port of the table memory while it walks the used
// rows and writes a row back in the cycle after its read, and then hands
// the result to the response register. A request that is not addressed
// to this node reads no rows. Reset clears the fill count and the
// handshake state and sets the configuration registers to their reset
// values; the table memory itself is not cleared, since only rows below
// the fill count are ever read. A stalled response waits in the response
// register while the next request is already taken and worked on.
//
// A route response first searches the used rows for its destination; the
// lowest match gets the new hop and a reloaded life, otherwise the route is
// appended. When the table is full the response is dropped and the table is
// compacted in place: rows with a nonzero life slide down in order. An aging
// tick decrements each nonzero life among the used rows.
module route_table_with_aging (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rta_pkg::in_req_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rta_pkg::out_rsp_t           out_rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rta_pkg::PaddrW-1:0]  paddr,
  input  logic [rta_pkg::PdataW-1:0]  pwdata,
  output logic [rta_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);

  rta_pkg::cfg_t    cfg;
  rta_pkg::mem_rd_t mem_rd;
  rta_pkg::mem_wr_t mem_wr;
  rta_pkg::entry_t  mem_rdata;

  // Node id and life reload registers.
  rta_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The route table: one row per route, with registered read data.
  rta_table_mem u_mem (
    .clk_i   (clk_i),
    .rd_i    (mem_rd),
    .wr_i    (mem_wr),
    .rdata_o (mem_rdata)
  );

  // Sequencer that walks the table and builds each response.
  rta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .rd_o        (mem_rd),
    .wr_o        (mem_wr),
    .rdata_i     (mem_rdata)
  );

endmodule

// ----- dv/tb_route_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// Route table with aging testbench
// Sends route responses and aging ticks with random gaps and stalls and
// checks each response against a cycle-free model of the route table that
// runs in this bench.
// ----------------------------------------------------------------------------
module tb_route_table_with_aging;

  // Settle a little past the longest request.
  localparam int unsigned SettleCycles = rta_pkg::TableDepth + 8;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned HoldAtRsp    = 150;
  localparam int unsigned MaxGap       = 12;
  localparam int unsigned PhaseItems   = 380;
  localparam int unsigned ReportMax    = 10;

  logic                         clk_i   = 1'b0;
  logic                         rst_ni  = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready_o;
  rta_pkg::in_req_t             in_req  = '0;
  logic                         out_valid_o;
  logic                         out_ready = 1'b0;
  rta_pkg::out_rsp_t            out_rsp_o;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [rta_pkg::PaddrW-1:0]   paddr   = '0;
  logic [rta_pkg::PdataW-1:0]   pwdata  = '0;
  logic [rta_pkg::PdataW-1:0]   prdata;
  logic                         pready;

  route_table_with_aging u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bench copy of the route table and its registers. Only rows below the
  // fill level are ever looked at, matching the block's own contract.
  rta_pkg::addr_t tbl_dest [rta_pkg::TableDepth];
  rta_pkg::addr_t tbl_hop  [rta_pkg::TableDepth];
  rta_pkg::life_t tbl_life [rta_pkg::TableDepth];
  int unsigned    tbl_fill = 0;
  rta_pkg::addr_t own_id    = rta_pkg::OwnNodeIdReset;
  rta_pkg::life_t life_init = rta_pkg::LifeReloadReset;

  // Requests waiting for the driver, and responses owed by the block in the
  // order their requests were accepted.
  rta_pkg::in_req_t  req_backlog_q [$];
  rta_pkg::out_rsp_t rsp_due_q [$];

  int unsigned mismatch_cnt = 0;

  // Handshake pacing state, owned by the driver and the monitor processes.
  int unsigned send_wait = 0;
  int unsigned take_wait = 0;
  bit          snd_burst = 1'b0;
  bit          rcv_burst = 1'b0;
  int unsigned rsp_seen  = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic rta_pkg::in_req_t make_req(logic cmd, rta_pkg::addr_t target,
                                                rta_pkg::addr_t dest, rta_pkg::addr_t hop);
    rta_pkg::in_req_t r;
    r.cmd         = cmd;
    r.resp_target = target;
    r.route_dest  = dest;
    r.hop_addr    = hop;
    return r;
  endfunction

  // Applies one request to the bench table and returns the response that the
  // block owes for it.
  function automatic rta_pkg::out_rsp_t apply_route_request(rta_pkg::in_req_t r);
    rta_pkg::out_rsp_t rsp;
    int unsigned       k;
    int unsigned       kept;
    bit                hit;
    rsp = '0;
    if (r.cmd == rta_pkg::CMD_AGE) begin
      // A tick only touches used rows and never wraps a dead life.
      for (k = 0; k < tbl_fill; k++) begin
        if (tbl_life[k] != '0) tbl_life[k] = tbl_life[k] - 1'b1;
      end
      rsp.status = rta_pkg::STATUS_AGED;
    end else if (r.resp_target != own_id) begin
      rsp.status = rta_pkg::STATUS_NOT_ADDRESSED;
    end else if (tbl_fill < rta_pkg::TableDepth) begin
      // The lowest row with this destination wins, even when its life is out.
      hit = 1'b0;
      for (k = 0; k < tbl_fill && !hit; k++) begin
        if (tbl_dest[k] == r.route_dest) begin
          tbl_hop[k]  = r.hop_addr;
          tbl_life[k] = life_init;
          rsp.status  = rta_pkg::STATUS_UPDATED;
          rsp.slot    = rta_pkg::slot_t'(k);
          hit         = 1'b1;
        end
      end
      if (!hit) begin
        tbl_dest[tbl_fill] = r.route_dest;
        tbl_hop[tbl_fill]  = r.hop_addr;
        tbl_life[tbl_fill] = life_init;
        rsp.status = rta_pkg::STATUS_INSERTED;
        rsp.slot   = rta_pkg::slot_t'(tbl_fill);
        tbl_fill++;
      end
    end else begin
      // Full table: the response is dropped and live rows slide down in order.
      kept = 0;
      for (k = 0; k < tbl_fill; k++) begin
        if (tbl_life[k] != '0) begin
          tbl_dest[kept] = tbl_dest[k];
          tbl_hop[kept]  = tbl_hop[k];
          tbl_life[kept] = tbl_life[k];
          kept++;
        end
      end
      tbl_fill   = kept;
      rsp.status = rta_pkg::STATUS_FULL_COMPACTED;
    end
    rsp.used_count = rta_pkg::used_t'(tbl_fill);
    return rsp;
  endfunction

  function automatic void note_mismatch(string what, rta_pkg::out_rsp_t want,
                                        rta_pkg::out_rsp_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportMax) begin
      $display("%s: expected status %0d slot %0d used %0d, got status %0d slot %0d used %0d",
               what, want.status, want.slot, want.used_count,
               got.status, got.slot, got.used_count);
    end
  endfunction

  // Random request for the current register setting. Most traffic is
  // addressed to this node and draws its destination from a small pool so
  // that updates, a full table and compaction all come up often.
  function automatic rta_pkg::in_req_t random_request(int unsigned tick_pct,
                                                      rta_pkg::addr_t dest_base);
    rta_pkg::in_req_t r;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    r = make_req(rta_pkg::CMD_RESPONSE, own_id, rta_pkg::addr_t'($urandom),
                 rta_pkg::addr_t'($urandom));
    if (roll < tick_pct) begin
      r.cmd         = rta_pkg::CMD_AGE;
      r.resp_target = rta_pkg::addr_t'($urandom);
    end else if (roll < tick_pct + 8) begin
      r.resp_target = own_id ^ rta_pkg::addr_t'($urandom_range(1, 65535));
    end else if ($urandom_range(0, 9) < 7) begin
      r.route_dest = dest_base + rta_pkg::addr_t'($urandom_range(0, 47));
    end
    return r;
  endfunction

  // Register write followed by a read back, both as setup and access cycles.
  // The block is idle whenever this runs, so the bench copy changes at once.
  task automatic cfg_write(logic reg_idx, logic [rta_pkg::PdataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rta_pkg::PaddrW'(reg_idx) << rta_pkg::RegSel;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == rta_pkg::REG_OWN_NODE_ID) own_id = rta_pkg::addr_t'(value);
    else life_init = rta_pkg::life_t'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportMax) begin
        $display("register %0d read back %h, expected %h", reg_idx, prdata, value);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every request went out and every response came back, then
  // lets the block settle past its longest request.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_backlog_q.size() != 0 || in_valid || rsp_due_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Driver: keeps valid and the request steady until accepted, then waits a
  // drawn number of cycles before offering the next one. The expected
  // response is worked out at the accepting edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_req    <= '0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        rsp_due_q.push_back(apply_route_request(in_req));
        send_wait = draw_wait(snd_burst);
        if ($urandom_range(0, 63) == 0) snd_burst = !snd_burst;
      end
      if (!in_valid || in_ready_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (req_backlog_q.size() > 0) begin
          in_req   <= req_backlog_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted response against the oldest one owed and
  // holds ready low for a drawn number of cycles after each. Once during the
  // run it holds off for a long stretch so the block backs up and stalls
  // its request side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (rsp_due_q.size() == 0) begin
          note_mismatch("response with none owed", '0, out_rsp_o);
        end else if (out_rsp_o.status !== rsp_due_q[0].status
                  || out_rsp_o.slot !== rsp_due_q[0].slot
                  || out_rsp_o.used_count !== rsp_due_q[0].used_count) begin
          note_mismatch("response mismatch", rsp_due_q.pop_front(), out_rsp_o);
        end else begin
          void'(rsp_due_q.pop_front());
        end
        rsp_seen++;
        take_wait = draw_wait(rcv_burst);
        if (rsp_seen == HoldAtRsp) take_wait = LongHold;
        if ($urandom_range(0, 63) == 0) rcv_burst = !rcv_burst;
      end else if (take_wait > 0) begin
        take_wait--;
      end
      out_ready <= (take_wait == 0);
    end
  end

  // Watchdog: a correct block never goes this long without a handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("[route_table_with_aging] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    rta_pkg::addr_t id_plan   [5];
    rta_pkg::life_t life_plan [5];
    int unsigned    tick_plan [5];
    int unsigned    ph;
    int unsigned    n;
    rta_pkg::addr_t dest_base;

    id_plan   = '{16'h0000, 16'hFFFF, rta_pkg::addr_t'($urandom),
                  rta_pkg::addr_t'($urandom), rta_pkg::addr_t'($urandom)};
    life_plan = '{8'd3, 8'd255, 8'd0, 8'd1, rta_pkg::life_t'($urandom_range(2, 8))};
    tick_plan = '{12, 25, 10, 12, 15};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests on the reset register values: node id zero and a
    // reload of three. They cover a tick on an empty table, a response for
    // another node, inserts and updates with extreme addresses, lives run
    // down to zero by ticks, and an update of a row whose life is out.
    @(negedge clk_i);
    req_backlog_q.push_back(make_req(rta_pkg::CMD_AGE, '1, '1, '1));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_RESPONSE, 16'hFFFF, 16'h0005, 16'h0006));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_RESPONSE, 16'h0000, 16'h0000, 16'h0000));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_RESPONSE, 16'h0000, 16'hFFFF, 16'hFFFF));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_RESPONSE, 16'h0000, 16'h0000, 16'hFFFF));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_AGE, '0, '0, '0));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_RESPONSE, 16'h0000, 16'h1234, 16'h0000));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_AGE, '0, '0, '0));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_AGE, '1, '0, '1));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_AGE, '0, '1, '0));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_RESPONSE, 16'h0000, 16'hFFFF, 16'h5555));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_RESPONSE, 16'h0001, 16'hFFFF, 16'hAAAA));
    req_backlog_q.push_back(make_req(rta_pkg::CMD_RESPONSE, 16'h0000, 16'hAAAA, 16'h5555));
    wait_drained();

    // Random phases, each on its own register setting. The table carries
    // over from one phase to the next. A zero reload makes every new row
    // dead on arrival, so only carried-over rows with a nonzero life survive
    // compaction; the largest reload keeps a full table full through compaction.
    for (ph = 0; ph < 5; ph++) begin
      cfg_write(rta_pkg::REG_OWN_NODE_ID, rta_pkg::PdataW'(id_plan[ph]));
      cfg_write(rta_pkg::REG_LIFE_RELOAD, rta_pkg::PdataW'(life_plan[ph]));
      dest_base = rta_pkg::addr_t'($urandom);
      @(negedge clk_i);
      for (n = 0; n < PhaseItems; n++) begin
        req_backlog_q.push_back(random_request(tick_plan[ph], dest_base));
      end
      wait_drained();
    end

    if (mismatch_cnt == 0 && rsp_due_q.size() == 0) begin
      $display("[route_table_with_aging] OK");
    end else begin
      $display("[route_table_with_aging] ERROR");
    end
    $finish;
  end

endmodule
